// ===== rtl/lgge_pkg.sv =====
// shared types and constants for the life grid generation engine
package lgge_pkg;

	localparam int ROW_W = 6;
	localparam int COL_W = 6;
	localparam int AGE_IN_W = 8;
	localparam int LIVE_W = 13;
	localparam int GEN_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_STEP = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd64;

	typedef struct packed {
		logic [1:0] req_type;
		logic [ROW_W-1:0] cell_row;
		logic [COL_W-1:0] cell_col;
		logic alive_in;
		logic [AGE_IN_W-1:0] age_in;
	} req_t;

	typedef struct packed {
		logic alive_out;
		logic [AGE_IN_W-1:0] age_out;
		logic [LIVE_W-1:0] live_count;
		logic [GEN_W-1:0] generation_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic clr_en;
		logic cap;
		logic acc_rd;
		logic acc_wb;
		logic pre_en;
		logic row_en;
		logic k_clr;
		logic row_next;
		logic gen_inc;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic pre_last;
		logic row_k_last;
		logic row_last;
	} sts_t;

endpackage

// ===== rtl/lgge_ctrl.sv =====
// controller state machine: clearing pass, cell access and generation sweep sequencing
module lgge_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] req_type,
	input  lgge_pkg::sts_t sts,
	output lgge_pkg::cmd_t cmd,
	output logic busy,
	output logic done
);
	import lgge_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ACC_RD,
		S_ACC_WB,
		S_PRE,
		S_ROW,
		S_DRAIN,
		S_RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (start) begin
						case (req_type) inside
							REQ_WRITE, REQ_READ: state_q <= S_ACC_RD;
							REQ_STEP: state_q <= S_PRE;
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_ACC_RD: state_q <= S_ACC_WB;
				S_ACC_WB: state_q <= S_RESP;
				S_PRE: if (sts.pre_last) state_q <= S_ROW;
				S_ROW: if (sts.row_k_last) state_q <= S_DRAIN;
				S_DRAIN: state_q <= sts.row_last ? S_RESP : S_ROW;
				S_RESP: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clr_en = 1'b1;
			S_IDLE: begin
				cmd.cap = start;
				cmd.k_clr = start;
			end
			S_ACC_RD: cmd.acc_rd = 1'b1;
			S_ACC_WB: cmd.acc_wb = 1'b1;
			S_PRE: begin
				cmd.pre_en = 1'b1;
				cmd.k_clr = sts.pre_last;
			end
			S_ROW: begin
				cmd.row_en = 1'b1;
				cmd.k_clr = sts.row_k_last;
			end
			S_DRAIN: begin
				cmd.gen_inc = sts.row_last;
				cmd.row_next = !sts.row_last;
			end
			S_RESP: ;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

// ===== rtl/lgge_datapath.sv =====
// datapath: cell store, row copies, neighbor window, counters and config registers
module lgge_datapath #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int AGE_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  lgge_pkg::cmd_t cmd,
	output lgge_pkg::sts_t sts,
	input  lgge_pkg::req_t req,
	input  logic cfg_we,
	input  logic [lgge_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgge_pkg::CFG_DATA_W-1:0] cfg_data,
	output lgge_pkg::rsp_t rsp
);
	import lgge_pkg::*;

	localparam int RB = $clog2(MAX_ROWS);
	localparam int CB = $clog2(MAX_COLS);
	localparam int AW = RB + CB;
	localparam int DEPTH = 1 << AW;
	localparam int RDW = $clog2(MAX_ROWS + 1);
	localparam int CW = $clog2(MAX_COLS + 2);

	// configuration
	logic [CFG_DATA_W-1:0] rows_q, cols_q;
	logic [RDW-1:0] rows_v;
	logic [CW-1:0] cols_v, cols_p1;
	logic [RB-1:0] rows_m1;
	logic [CB-1:0] cols_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_RESET;
			cols_q <= DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROWS) rows_q <= cfg_data;
			if (cfg_index == CFG_COLS) cols_q <= cfg_data;
		end
	end

	always_comb begin
		if (rows_q < 7'd3) rows_v = RDW'(3);
		else if (32'(rows_q) > MAX_ROWS) rows_v = RDW'(MAX_ROWS);
		else rows_v = RDW'(rows_q);
		if (cols_q < 7'd3) cols_v = CW'(3);
		else if (32'(cols_q) > MAX_COLS) cols_v = CW'(MAX_COLS);
		else cols_v = CW'(cols_q);
	end

	assign rows_m1 = RB'(rows_v - RDW'(1));
	assign cols_m1 = CB'(cols_v - CW'(1));
	assign cols_p1 = cols_v + CW'(1);

	// memories
	logic alive_mem [DEPTH];
	logic [AGE_BITS-1:0] age_mem [DEPTH];
	logic pp0_mem [MAX_COLS];
	logic pp1_mem [MAX_COLS];
	logic rc0_mem [MAX_COLS];

	logic [AW-1:0] a_ra, b_ra, g_ra;
	logic a_rd, b_rd, pp0_rd, pp1_rd, rc0_rd;
	logic [AGE_BITS-1:0] g_rd;
	logic [CB-1:0] pp0_ra, pp1_ra, rc0_ra;

	logic al_we, ag_we;
	logic [AW-1:0] al_wa;
	logic al_wd;
	logic [AGE_BITS-1:0] ag_wd;
	logic pp0_we, pp1_we, rc0_we;
	logic pp_wd;

	// sequencing counters
	logic [AW-1:0] clr_q;
	logic [CW-1:0] k_q;
	logic [RB-1:0] r_q;
	logic par;
	logic [CB-1:0] rd_col, cell_col;

	// captured item
	req_t cap_q;
	logic in_store;
	logic [AW-1:0] acc_addr;

	// arrival tags
	logic pre_s1, row_s1;
	logic [CW-1:0] k_s1;
	logic [CB-1:0] col_s1, cell_s1;
	logic [RB-1:0] r_s1;
	logic last_row_s1;

	// neighbor window, {above, here, below}
	logic [2:0] wl_q, wc_q, nw;
	logic above, here, below;
	logic wrap_s1, calc, keep_copy;
	logic [3:0] n;
	logic now_alive, was_alive;
	logic [AGE_BITS-1:0] new_age;
	logic age_sat;
	logic inc_live, dec_live;
	logic is_wr, is_rd;

	logic [LIVE_W-1:0] live_q;
	logic [GEN_W-1:0] gen_q;
	logic rd_alive_q;
	logic [AGE_IN_W-1:0] rd_age_q;

	assign in_store = (32'(cap_q.cell_row) < MAX_ROWS) && (32'(cap_q.cell_col) < MAX_COLS);
	assign acc_addr = {RB'(cap_q.cell_row), CB'(cap_q.cell_col)};
	assign is_wr = (cap_q.req_type == REQ_WRITE) && in_store;
	assign is_rd = (cap_q.req_type == REQ_READ) && in_store;
	assign par = r_q[0];

	always_comb begin
		if (k_q == '0) rd_col = cols_m1;
		else if (k_q == cols_p1) rd_col = '0;
		else rd_col = CB'(k_q - CW'(1));
		if (cmd.pre_en) rd_col = CB'(k_q);
	end
	assign cell_col = CB'(k_q - CW'(2));

	// read address selection
	always_comb begin
		a_ra = {r_q, rd_col};
		b_ra = {RB'(r_q + RB'(1)), rd_col};
		g_ra = {r_q, cell_col};
		if (cmd.pre_en) begin
			a_ra = {rows_m1, rd_col};
			b_ra = {RB'(0), rd_col};
		end else if (cmd.acc_rd) begin
			a_ra = acc_addr;
			g_ra = acc_addr;
		end
		// above comes from the other parity copy, here-wrap from this row's copy
		pp0_ra = par ? rd_col : '0;
		pp1_ra = par ? '0 : rd_col;
		rc0_ra = rd_col;
	end

	// window arrival logic
	assign wrap_s1 = (k_s1 == cols_p1);
	assign calc = row_s1 && (k_s1 >= CW'(2));
	assign keep_copy = row_s1 && (k_s1 != '0) && !wrap_s1;
	assign above = r_s1[0] ? pp0_rd : pp1_rd;
	assign here = wrap_s1 ? (r_s1[0] ? pp1_rd : pp0_rd) : a_rd;
	assign below = last_row_s1 ? rc0_rd : b_rd;
	assign nw = {above, here, below};

	assign n = 4'(wl_q[0]) + 4'(wl_q[1]) + 4'(wl_q[2]) + 4'(wc_q[0]) + 4'(wc_q[2])
		+ 4'(nw[0]) + 4'(nw[1]) + 4'(nw[2]);
	assign was_alive = wc_q[1];
	assign age_sat = (g_rd == {AGE_BITS{1'b1}});

	always_comb begin
		now_alive = was_alive;
		new_age = g_rd;
		if (n == 4'd3) begin
			now_alive = 1'b1;
			if (!age_sat) new_age = g_rd + AGE_BITS'(1);
		end else if (n == 4'd2) begin
			if (was_alive && !age_sat) new_age = g_rd + AGE_BITS'(1);
		end else begin
			now_alive = 1'b0;
			new_age = '0;
		end
	end

	// single write port per store
	always_comb begin
		al_we = 1'b0;
		ag_we = 1'b0;
		al_wa = {r_s1, cell_s1};
		al_wd = now_alive;
		ag_wd = new_age;
		inc_live = 1'b0;
		dec_live = 1'b0;
		if (cmd.clr_en) begin
			al_we = 1'b1;
			ag_we = 1'b1;
			al_wa = clr_q;
			al_wd = 1'b0;
			ag_wd = '0;
		end else if (cmd.acc_wb && is_wr) begin
			al_we = 1'b1;
			ag_we = 1'b1;
			al_wa = acc_addr;
			al_wd = cap_q.alive_in;
			ag_wd = AGE_BITS'(cap_q.age_in);
			inc_live = !a_rd && cap_q.alive_in;
			dec_live = a_rd && !cap_q.alive_in;
		end else if (calc) begin
			al_we = 1'b1;
			ag_we = 1'b1;
			inc_live = !was_alive && now_alive;
			dec_live = was_alive && !now_alive;
		end
		pp_wd = pre_s1 ? a_rd : here;
		pp0_we = keep_copy && !r_s1[0];
		pp1_we = pre_s1 || (keep_copy && r_s1[0]);
		rc0_we = pre_s1;
	end

	always_ff @(posedge clk) begin
		a_rd <= alive_mem[a_ra];
		b_rd <= alive_mem[b_ra];
		if (al_we) alive_mem[al_wa] <= al_wd;
	end

	always_ff @(posedge clk) begin
		g_rd <= age_mem[g_ra];
		if (ag_we) age_mem[al_wa] <= ag_wd;
	end

	always_ff @(posedge clk) begin
		pp0_rd <= pp0_mem[pp0_ra];
		if (pp0_we) pp0_mem[col_s1] <= pp_wd;
	end

	always_ff @(posedge clk) begin
		pp1_rd <= pp1_mem[pp1_ra];
		if (pp1_we) pp1_mem[col_s1] <= pp_wd;
	end

	always_ff @(posedge clk) begin
		rc0_rd <= rc0_mem[rc0_ra];
		if (rc0_we) rc0_mem[col_s1] <= b_rd;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) cap_q <= req;
		k_s1 <= k_q;
		col_s1 <= rd_col;
		cell_s1 <= cell_col;
		r_s1 <= r_q;
		last_row_s1 <= (r_q == rows_m1);
		if (row_s1) begin
			wl_q <= wc_q;
			wc_q <= nw;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			k_q <= '0;
			r_q <= '0;
			pre_s1 <= 1'b0;
			row_s1 <= 1'b0;
			live_q <= '0;
			gen_q <= GEN_W'(1);
			rd_alive_q <= 1'b0;
			rd_age_q <= '0;
		end else begin
			pre_s1 <= cmd.pre_en;
			row_s1 <= cmd.row_en;
			if (cmd.clr_en) clr_q <= clr_q + AW'(1);
			if (cmd.k_clr) k_q <= '0;
			else if (cmd.pre_en || cmd.row_en) k_q <= k_q + CW'(1);
			if (cmd.cap) r_q <= '0;
			else if (cmd.row_next) r_q <= r_q + RB'(1);
			if (inc_live) live_q <= live_q + LIVE_W'(1);
			else if (dec_live) live_q <= live_q - LIVE_W'(1);
			if (cmd.gen_inc) gen_q <= gen_q + GEN_W'(1);
			if (cmd.cap) begin
				rd_alive_q <= 1'b0;
				rd_age_q <= '0;
			end else if (cmd.acc_wb && is_rd) begin
				rd_alive_q <= a_rd;
				rd_age_q <= AGE_IN_W'(g_rd);
			end
		end
	end

	assign sts.clr_last = (clr_q == {AW{1'b1}});
	// the copy pass runs past the last column so the last copy write lands before the sweep reads it back
	assign sts.pre_last = (k_q == cols_v);
	assign sts.row_k_last = (k_q == cols_p1);
	assign sts.row_last = (r_q == rows_m1);

	assign rsp.alive_out = rd_alive_q;
	assign rsp.age_out = rd_age_q;
	assign rsp.live_count = live_q;
	assign rsp.generation_count = gen_q;

endmodule

// ===== rtl/life_grid_generation_engine_unit.sv =====
// top level of the toroidal life grid generation engine
// After reset the block is busy for a clearing pass that zeroes the cell store, all
// 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (4096 by default), one cell per cycle. A write or
// read transaction is accepted when start is high and busy low; its result strobes on done
// after the controller passes its read and write-back states, and the next transaction can
// be taken in the cycle after done. A step transaction keeps busy high through a row-copy
// pass and then a sweep of one cell per cycle through the single write port of the cell
// store, with window fill and drain for every row. Results cannot be stalled: the outputs
// are valid in the cycle that done is high and hold until the next transaction is accepted.
// Configuration writes are always taken and should be made only while busy is low.
module life_grid_generation_engine_unit #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int AGE_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  lgge_pkg::req_t req,
	output logic done,
	output lgge_pkg::rsp_t rsp,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lgge_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgge_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lgge_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lgge_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(req.req_type),
		.sts(sts),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	lgge_datapath #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.AGE_BITS(AGE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.req(req),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rsp(rsp)
	);

	// an accepted transaction keeps the block busy until its result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// a result strobe is a single cycle and frees the block
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe not followed by idle");

	// results only come while the block is busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the life grid generation engine
`timescale 1ns / 1ps

module tb;
	import lgge_pkg::*;

	localparam int DIM = 64;
	localparam longint CYCLE_LIMIT = 3000000;

	// software copy of the grid, updated at once per generation
	class life_scoreboard;
		bit alive_grid [DIM][DIM];
		bit [7:0] age_grid [DIM][DIM];
		bit [12:0] live_total;
		bit [31:0] gen_number;
		int unsigned rows_cfg, cols_cfg;
		rsp_t pending [$];
		int errors;

		function void clear_all();
			foreach (alive_grid[r, c]) begin
				alive_grid[r][c] = 0;
				age_grid[r][c] = 0;
			end
			live_total = 0;
			gen_number = 1;
			rows_cfg = 64;
			cols_cfg = 64;
			errors = 0;
		endfunction

		function int unsigned clamp_dim(int unsigned v);
			if (v < 3) return 3;
			if (v > DIM) return DIM;
			return v;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_ROWS) rows_cfg = 32'(val);
			else if (idx == CFG_COLS) cols_cfg = 32'(val);
		endfunction

		function void next_generation();
			bit snap [DIM][DIM];
			int unsigned nr, nc, n;
			int unsigned up, dn, lf, rt;
			nr = clamp_dim(rows_cfg);
			nc = clamp_dim(cols_cfg);
			snap = alive_grid;
			for (int r = 0; r < nr; r++) begin
				for (int c = 0; c < nc; c++) begin
					up = (r + nr - 1) % nr;
					dn = (r + 1) % nr;
					lf = (c + nc - 1) % nc;
					rt = (c + 1) % nc;
					n = snap[up][lf] + snap[up][c] + snap[up][rt] + snap[r][lf] + snap[r][rt]
						+ snap[dn][lf] + snap[dn][c] + snap[dn][rt];
					if (n == 3) begin
						if (!snap[r][c]) live_total++;
						alive_grid[r][c] = 1;
						if (age_grid[r][c] != 8'hFF) age_grid[r][c]++;
					end else if (n == 2) begin
						if (snap[r][c] && age_grid[r][c] != 8'hFF) age_grid[r][c]++;
					end else begin
						if (snap[r][c]) live_total--;
						alive_grid[r][c] = 0;
						age_grid[r][c] = 0;
					end
				end
			end
			gen_number++;
		endfunction

		function void note_request(req_t q);
			rsp_t e;
			e = '0;
			case (q.req_type)
				REQ_WRITE: begin
					if (alive_grid[q.cell_row][q.cell_col] && !q.alive_in) live_total--;
					if (!alive_grid[q.cell_row][q.cell_col] && q.alive_in) live_total++;
					alive_grid[q.cell_row][q.cell_col] = q.alive_in;
					age_grid[q.cell_row][q.cell_col] = q.age_in;
				end
				REQ_STEP: next_generation();
				REQ_READ: begin
					e.alive_out = alive_grid[q.cell_row][q.cell_col];
					e.age_out = age_grid[q.cell_row][q.cell_col];
				end
				default: ;
			endcase
			e.live_count = live_total;
			e.generation_count = gen_number;
			pending.push_back(e);
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.alive_out !== e.alive_out) begin
				$error("alive_out expected %0d actual %0d", e.alive_out, a.alive_out);
				errors++;
			end
			if (a.age_out !== e.age_out) begin
				$error("age_out expected %0d actual %0d", e.age_out, a.age_out);
				errors++;
			end
			if (a.live_count !== e.live_count) begin
				$error("live_count expected %0d actual %0d", e.live_count, a.live_count);
				errors++;
			end
			if (a.generation_count !== e.generation_count) begin
				$error("generation_count expected %0d actual %0d", e.generation_count,
					a.generation_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	life_scoreboard grid_sb;
	longint cycle_count = 0;
	int steps_sent = 0, reads_sent = 0, writes_sent = 0;
	// grid size of the current phase, used to aim addresses
	int unsigned aim_rows = 64, aim_cols = 64;

	always #5 clk = ~clk;

	life_grid_generation_engine_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && done) grid_sb.check_response(rsp);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// start stays high into the next transaction when there is no gap
	task automatic send_request(req_t q);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		req <= q;
		do @(posedge clk); while (busy !== 1'b0);
		grid_sb.note_request(q);
		case (q.req_type)
			REQ_STEP: steps_sent++;
			REQ_READ: reads_sent++;
			REQ_WRITE: writes_sent++;
			default: ;
		endcase
	endtask

	task automatic make_request(logic [1:0] t, int r, int c, bit a, int age);
		req_t q;
		q.req_type = t;
		q.cell_row = ROW_W'(r);
		q.cell_col = COL_W'(c);
		q.alive_in = a;
		q.age_in = AGE_IN_W'(age);
		send_request(q);
	endtask

	task automatic drain_results();
		start <= 0;
		while (grid_sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		grid_sb.set_register(idx, val);
	endtask

	task automatic set_grid(int r, int c);
		drain_results();
		write_register(CFG_ROWS, CFG_DATA_W'(r));
		write_register(CFG_COLS, CFG_DATA_W'(c));
		cfg_valid <= 0;
		aim_rows = grid_sb.clamp_dim(r);
		aim_cols = grid_sb.clamp_dim(c);
	endtask

	// mostly cells in the active window, some anywhere in the store
	task automatic random_item(int step_pct);
		int p, r, c;
		p = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			r = $urandom_range(0, 63);
			c = $urandom_range(0, 63);
		end else begin
			r = $urandom_range(0, aim_rows - 1);
			c = $urandom_range(0, aim_cols - 1);
		end
		if (p < step_pct) make_request(REQ_STEP, 0, 0, 0, 0);
		else if (p < step_pct + 40)
			make_request(REQ_WRITE, r, c, $urandom_range(0, 3) != 0, $urandom_range(0, 255));
		else if (p < 97) make_request(REQ_READ, r, c, 1'($urandom), $urandom);
		else make_request(2'd3, r, c, 1'($urandom), $urandom);
	endtask

	initial begin
		grid_sb = new();
		grid_sb.clear_all();
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// corners and extremes on a small torus
		set_grid(3, 3);
		make_request(REQ_WRITE, 0, 0, 1, 255);
		make_request(REQ_WRITE, 0, 1, 1, 254);
		make_request(REQ_WRITE, 1, 0, 1, 0);
		make_request(REQ_WRITE, 63, 63, 1, 170);
		make_request(REQ_WRITE, 2, 2, 0, 85);
		make_request(REQ_READ, 63, 63, 0, 0);
		make_request(REQ_READ, 0, 0, 0, 0);
		make_request(REQ_STEP, 0, 0, 0, 0);
		make_request(REQ_READ, 2, 2, 0, 0);
		make_request(2'd3, 42, 21, 1, 255);
		make_request(REQ_STEP, 0, 0, 0, 0);
		make_request(REQ_WRITE, 0, 0, 0, 0);
		make_request(REQ_READ, 1, 1, 0, 0);
		// blinker across the wrap of a 5 by 5 grid
		set_grid(5, 5);
		make_request(REQ_WRITE, 4, 0, 1, 10);
		make_request(REQ_WRITE, 0, 0, 1, 11);
		make_request(REQ_WRITE, 1, 0, 1, 12);
		make_request(REQ_STEP, 0, 0, 0, 0);
		make_request(REQ_STEP, 0, 0, 0, 0);
		make_request(REQ_READ, 0, 4, 0, 0);
		make_request(REQ_READ, 0, 0, 0, 0);

		// random phases, out-of-range register values clamp
		set_grid(0, 127);
		repeat (12) random_item(6);
		set_grid(8, 6);
		repeat (40) random_item(15);
		set_grid(64, 3);
		repeat (25) random_item(8);
		set_grid(13, 10);
		repeat (25) random_item(15);
		set_grid(64, 64);
		repeat (20) random_item(5);

		drain_results();
		$display("covered %0d writes, %0d reads, %0d generations over several grid sizes",
			writes_sent, reads_sent, steps_sent);
		if (grid_sb.errors == 0 && grid_sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/lgge_pkg.sv
rtl/lgge_ctrl.sv
rtl/lgge_datapath.sv
rtl/life_grid_generation_engine_unit.sv
tb/tb.sv
